@@ hw/rtl/ptw_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker package
// Shared constants, codes and types of the four-level page table walker.
// ----------------------------------------------------------------------------
package ptw_pkg;

	localparam int unsigned STORE_WORDS_DEF = 4096;

	localparam int unsigned VA_W    = 48;
	localparam int unsigned PA_W    = 52;
	localparam int unsigned FRAME_W = 40;
	localparam int unsigned WIDX_W  = 12;
	localparam int unsigned WORD_W  = 64;
	localparam int unsigned FAULT_W = 3;
	localparam int unsigned SIZE_W  = 2;
	localparam int unsigned IDX_W   = 9;
	localparam int unsigned LEVEL_W = 2;
	// Word number of an entry: frame * 512 + index, one bit of headroom.
	localparam int unsigned WNUM_W  = FRAME_W + IDX_W + 1;

	// Item function codes.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_XLATE = 1'b1;

	// Fault codes.
	localparam logic [FAULT_W-1:0] FAULT_NONE    = 3'd0;
	localparam logic [FAULT_W-1:0] FAULT_OUTSIDE = 3'd5;

	// Page size codes.
	localparam logic [SIZE_W-1:0] SIZE_NONE = 2'd0;
	localparam logic [SIZE_W-1:0] SIZE_4K   = 2'd1;
	localparam logic [SIZE_W-1:0] SIZE_2M   = 2'd2;
	localparam logic [SIZE_W-1:0] SIZE_1G   = 2'd3;

	// Walk levels.
	localparam logic [LEVEL_W-1:0] LVL_PML4 = 2'd0;
	localparam logic [LEVEL_W-1:0] LVL_PDPT = 2'd1;
	localparam logic [LEVEL_W-1:0] LVL_PD   = 2'd2;
	localparam logic [LEVEL_W-1:0] LVL_PT   = 2'd3;

	// Entry bits.
	localparam int unsigned PRESENT_BIT = 0;
	localparam int unsigned LARGE_BIT   = 7;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_EVAL,
		ST_FINISH
	} ptw_state_t;

endpackage

@@ hw/rtl/ptw_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walker channels
// Input item channel and result channel, each with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptw_in_if
	import ptw_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic                func;
	logic [VA_W-1:0]     virt_addr;
	logic [WIDX_W-1:0]   word_index;
	logic [WORD_W-1:0]   word_data;

	modport source (output valid, func, virt_addr, word_index, word_data,
		input ready);
	modport sink (input valid, func, virt_addr, word_index, word_data,
		output ready);
endinterface

interface ptw_out_if
	import ptw_pkg::*;
	;
	logic                valid;
	logic                ready;
	logic [PA_W-1:0]     phys_addr;
	logic [FAULT_W-1:0]  fault;
	logic [SIZE_W-1:0]   page_size;

	modport source (output valid, phys_addr, fault, page_size, input ready);
	modport sink (input valid, phys_addr, fault, page_size, output ready);
endinterface

@@ hw/rtl/ptw_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table store
// Single-port store of 64-bit table words with a registered read.
// ----------------------------------------------------------------------------
module ptw_store
	import ptw_pkg::*;
#(
	parameter int unsigned STORE_WORDS = STORE_WORDS_DEF,
	localparam int unsigned AW = $clog2(STORE_WORDS)
) (
	input  logic              clk,
	input  logic              we,
	input  logic              re,
	input  logic [AW-1:0]     addr,
	input  logic [WORD_W-1:0] wdata,
	output logic [WORD_W-1:0] rdata
);

	logic [WORD_W-1:0] mem_q [STORE_WORDS];
	logic [WORD_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ hw/rtl/ptw_seq.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Page table walk sequencer
// Steps one walk level at a time through the shared address unit and store.
// ----------------------------------------------------------------------------
module ptw_seq
	import ptw_pkg::*;
#(
	parameter int unsigned STORE_WORDS = STORE_WORDS_DEF,
	localparam int unsigned AW = $clog2(STORE_WORDS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FRAME_W-1:0] cfg_wdata,
	ptw_in_if.sink             in_ch,
	ptw_out_if.source          out_ch,
	output logic               mem_we,
	output logic               mem_re,
	output logic [AW-1:0]      mem_addr,
	output logic [WORD_W-1:0]  mem_wdata,
	input  logic [WORD_W-1:0]  mem_rdata
);

	ptw_state_t          state_q, state_d;
	logic [FRAME_W-1:0]  base_frame_q;
	logic [VA_W-1:0]     va_q;
	logic [FRAME_W-1:0]  frame_q;
	logic [LEVEL_W-1:0]  level_q;
	logic [PA_W-1:0]     res_pa_q;
	logic [FAULT_W-1:0]  res_fault_q;
	logic [SIZE_W-1:0]   res_size_q;
	logic                out_valid_q;
	logic [PA_W-1:0]     out_pa_q;
	logic [FAULT_W-1:0]  out_fault_q;
	logic [SIZE_W-1:0]   out_size_q;

	logic                accept;
	logic                widx_ok;
	logic [IDX_W-1:0]    idx;
	logic [WNUM_W-1:0]   wnum;
	logic                outside;
	logic                slot_free;
	logic                ev_absent;
	logic                ev_descend;
	logic [PA_W-1:0]     ev_pa;
	logic [SIZE_W-1:0]   ev_size;

	assign in_ch.ready = (state_q == ST_IDLE);
	assign accept      = in_ch.valid && in_ch.ready;
	assign slot_free   = !out_valid_q || out_ch.ready;
	assign widx_ok     = (32'(in_ch.word_index) < 32'(STORE_WORDS));

	// Shared address unit: table index for the current level and entry word number.
	always_comb begin
		case (level_q)
			LVL_PML4: idx = va_q[47:39];
			LVL_PDPT: idx = va_q[38:30];
			LVL_PD:   idx = va_q[29:21];
			default:  idx = va_q[20:12];
		endcase
		wnum    = {1'b0, frame_q, {IDX_W{1'b0}}} + WNUM_W'(idx);
		outside = (wnum >= WNUM_W'(STORE_WORDS));
	end

	// Entry decode for the word just read.
	always_comb begin
		ev_absent  = !mem_rdata[PRESENT_BIT];
		ev_descend = 1'b0;
		ev_pa      = '0;
		ev_size    = SIZE_NONE;
		if (!ev_absent) begin
			if (level_q == LVL_PDPT && mem_rdata[LARGE_BIT]) begin
				ev_pa   = {mem_rdata[51:30], va_q[29:0]};
				ev_size = SIZE_1G;
			end else if (level_q == LVL_PD && mem_rdata[LARGE_BIT]) begin
				ev_pa   = {mem_rdata[51:21], va_q[20:0]};
				ev_size = SIZE_2M;
			end else if (level_q == LVL_PT) begin
				ev_pa   = {mem_rdata[51:12], va_q[11:0]};
				ev_size = SIZE_4K;
			end else begin
				ev_descend = 1'b1;
			end
		end
	end

	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_addr  = wnum[AW-1:0];
		mem_wdata = in_ch.word_data;
		case (state_q)
			ST_IDLE: begin
				mem_addr = AW'(32'(in_ch.word_index));
				if (accept) begin
					if (in_ch.func == FUNC_WRITE) begin
						mem_we  = widx_ok;
						state_d = ST_FINISH;
					end else begin
						state_d = ST_LOOKUP;
					end
				end
			end
			ST_LOOKUP: begin
				if (outside) begin
					state_d = ST_FINISH;
				end else begin
					mem_re  = 1'b1;
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				state_d = ev_descend ? ST_LOOKUP : ST_FINISH;
			end
			ST_FINISH: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			base_frame_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				base_frame_q <= cfg_wdata;
			end
			if (state_q == ST_FINISH && slot_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					va_q        <= in_ch.virt_addr;
					frame_q     <= base_frame_q;
					level_q     <= LVL_PML4;
					res_pa_q    <= '0;
					res_fault_q <= FAULT_NONE;
					res_size_q  <= SIZE_NONE;
				end
			end
			ST_LOOKUP: begin
				if (outside) begin
					res_fault_q <= FAULT_OUTSIDE;
				end
			end
			ST_EVAL: begin
				if (ev_absent) begin
					res_fault_q <= FAULT_W'(level_q) + FAULT_W'(1);
				end else if (ev_descend) begin
					frame_q <= mem_rdata[51:12];
					level_q <= level_q + LEVEL_W'(1);
				end else begin
					res_pa_q   <= ev_pa;
					res_size_q <= ev_size;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					out_pa_q    <= res_pa_q;
					out_fault_q <= res_fault_q;
					out_size_q  <= res_size_q;
				end
			end
			default: ;
		endcase
	end

	assign out_ch.valid     = out_valid_q;
	assign out_ch.phys_addr = out_pa_q;
	assign out_ch.fault     = out_fault_q;
	assign out_ch.page_size = out_size_q;

endmodule

@@ hw/rtl/four_level_page_table_walker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-level page table walker
// Holds page-table words in a local store and walks them to translate
// 48-bit virtual addresses, or writes one store word per item.
// ----------------------------------------------------------------------------
// Sequence: a write item goes from idle to finish; a translation passes a lookup and an
// evaluate state per table read, then finish, and an entry address beyond the store
// ends the walk after its lookup without a read. Finish waits while a result is untaken.
// One item at a time: a new item is taken only in idle; the single-port store is
// read once per level, each read through a lookup state and an evaluate state.
// Reset: arst_n clears the sequencer, the result valid flag and the root frame
// register; the store itself is not cleared and holds undefined data until written.

module four_level_page_table_walker_top
	import ptw_pkg::*;
#(
	parameter int unsigned STORE_WORDS = STORE_WORDS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [FRAME_W-1:0] cfg_wdata,
	ptw_in_if.sink             in_ch,
	ptw_out_if.source          out_ch
);

	localparam int unsigned AW = $clog2(STORE_WORDS);

	// Store port, owned by the sequencer. Writes happen on the transfer edge
	// of a write item; reads are issued once per walk level.
	logic              mem_we;
	logic              mem_re;
	logic [AW-1:0]     mem_addr;
	logic [WORD_W-1:0] mem_wdata;
	logic [WORD_W-1:0] mem_rdata;

	// The sequencer holds the root frame register, the walk state and the
	// output register, so a finished result can wait while the next item is taken.
	ptw_seq #(
		.STORE_WORDS (STORE_WORDS)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.mem_we    (mem_we),
		.mem_re    (mem_re),
		.mem_addr  (mem_addr),
		.mem_wdata (mem_wdata),
		.mem_rdata (mem_rdata)
	);

	// The table store: one port, registered read data.
	ptw_store #(
		.STORE_WORDS (STORE_WORDS)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.re    (mem_re),
		.addr  (mem_addr),
		.wdata (mem_wdata),
		.rdata (mem_rdata)
	);

endmodule

@@ sim/tb_four_level_page_table_walker_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Four-level page table walker testbench
// Builds page tables in the walker's store through write items, translates
// directed and random addresses under several root frames, and checks every
// result against a scoreboard that walks its own copy of the tables.
// ----------------------------------------------------------------------------
module tb_four_level_page_table_walker_top
	import ptw_pkg::*;
	;

	// Absent-entry fault codes, one per level of the walk.
	localparam logic [FAULT_W-1:0] FAULT_ABSENT_PML4 = 3'd1;
	localparam logic [FAULT_W-1:0] FAULT_ABSENT_PDPT = 3'd2;
	localparam logic [FAULT_W-1:0] FAULT_ABSENT_PD   = 3'd3;
	localparam logic [FAULT_W-1:0] FAULT_ABSENT_PT   = 3'd4;

	// Number of whole 512-entry tables that fit in the store.
	localparam int unsigned TABLES_IN_STORE = STORE_WORDS_DEF / 512;
	localparam int unsigned REPORT_LIMIT = 10;

	typedef struct packed {
		logic               func;
		logic [VA_W-1:0]    va;
		logic [WIDX_W-1:0]  widx;
		logic [WORD_W-1:0]  wdata;
	} walker_item_t;

	typedef struct packed {
		logic [PA_W-1:0]    pa;
		logic [FAULT_W-1:0] fault;
		logic [SIZE_W-1:0]  size;
	} xlate_result_t;

	// Maps a walk level onto the fault code for an absent entry there.
	function automatic logic [FAULT_W-1:0] absent_fault(input logic [LEVEL_W-1:0] lvl);
		case (lvl)
			LVL_PML4: return FAULT_ABSENT_PML4;
			LVL_PDPT: return FAULT_ABSENT_PDPT;
			LVL_PD:   return FAULT_ABSENT_PD;
			default:  return FAULT_ABSENT_PT;
		endcase
	endfunction

	// Mirror of the walker's store and root frame, and the queue of results
	// that the walker still owes.
	class walk_scoreboard;
		logic [WORD_W-1:0]  table_words [STORE_WORDS_DEF];
		bit                 word_written [STORE_WORDS_DEF];
		logic [FRAME_W-1:0] root_frame;
		xlate_result_t      owed_results [$];
		int unsigned        mismatches;
		int unsigned        strays;
		int unsigned        n_writes;
		int unsigned        n_xlates;
		int unsigned        fault_hits [6];
		int unsigned        size_hits [4];

		function new();
			root_frame = '0;
			mismatches = 0;
			strays = 0;
			n_writes = 0;
			n_xlates = 0;
			foreach (word_written[i]) word_written[i] = 1'b0;
			foreach (fault_hits[i]) fault_hits[i] = 0;
			foreach (size_hits[i]) size_hits[i] = 0;
		endfunction

		function void set_root(input logic [FRAME_W-1:0] frame);
			root_frame = frame;
		endfunction

		function int pending();
			return owed_results.size();
		endfunction

		// Walks the mirrored tables. gap_word returns the first store word the
		// walk would read without it ever having been written, or -1.
		function void walk_tables(input logic [VA_W-1:0] va, output xlate_result_t res,
				output int gap_word, output int gap_level);
			logic [FRAME_W-1:0] frame;
			logic [WNUM_W-1:0]  wnum;
			logic [WORD_W-1:0]  entry;
			logic [IDX_W-1:0]   idx;
			logic [LEVEL_W-1:0] lvl;
			bit                 done;
			int                 l;
			res = '0;
			gap_word = -1;
			gap_level = -1;
			frame = root_frame;
			done = 1'b0;
			for (l = 0; l < 4 && !done; l++) begin
				lvl = LEVEL_W'(l);
				idx = va[(39 - 9 * l) +: IDX_W];
				// frame * 512 + index is just the two fields side by side.
				wnum = {1'b0, frame, idx};
				done = 1'b1;
				if (wnum >= STORE_WORDS_DEF) begin
					res.fault = FAULT_OUTSIDE;
				end else if (!word_written[wnum]) begin
					gap_word = int'(wnum);
					gap_level = l;
					res.fault = absent_fault(lvl);
				end else begin
					entry = table_words[wnum];
					if (!entry[PRESENT_BIT]) begin
						res.fault = absent_fault(lvl);
					end else if (lvl == LVL_PDPT && entry[LARGE_BIT]) begin
						res.pa = {entry[51:30], va[29:0]};
						res.size = SIZE_1G;
					end else if (lvl == LVL_PD && entry[LARGE_BIT]) begin
						res.pa = {entry[51:21], va[20:0]};
						res.size = SIZE_2M;
					end else if (lvl == LVL_PT) begin
						res.pa = {entry[51:12], va[11:0]};
						res.size = SIZE_4K;
					end else begin
						frame = entry[51:12];
						done = 1'b0;
					end
				end
			end
		endfunction

		function void note_item(input walker_item_t it);
			xlate_result_t res;
			int            gw;
			int            gl;
			if (it.func == FUNC_WRITE) begin
				if (it.widx < STORE_WORDS_DEF) begin
					table_words[it.widx] = it.wdata;
					word_written[it.widx] = 1'b1;
				end
				res = '0;
				n_writes++;
			end else begin
				walk_tables(it.va, res, gw, gl);
				n_xlates++;
				fault_hits[res.fault]++;
				size_hits[res.size]++;
			end
			owed_results.push_back(res);
		endfunction

		function void check_result(input xlate_result_t got);
			xlate_result_t want;
			if (owed_results.size() == 0) begin
				strays++;
				if (mismatches + strays <= REPORT_LIMIT)
					$display("%0t: unexpected result pa=%h fault=%0d size=%0d",
						$realtime, got.pa, got.fault, got.size);
				return;
			end
			want = owed_results.pop_front();
			if (got.pa !== want.pa || got.fault !== want.fault || got.size !== want.size) begin
				mismatches++;
				if (mismatches + strays <= REPORT_LIMIT) begin
					$display("%0t: result mismatch: expected pa=%h fault=%0d size=%0d",
						$realtime, want.pa, want.fault, want.size);
					$display("%0t: result mismatch: got pa=%h fault=%0d size=%0d",
						$realtime, got.pa, got.fault, got.size);
				end
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               cfg_we;
	logic [FRAME_W-1:0] cfg_wdata;

	ptw_in_if  in_ch ();
	ptw_out_if out_ch ();

	four_level_page_table_walker_top #(
		.STORE_WORDS(STORE_WORDS_DEF)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_ch    (in_ch),
		.out_ch   (out_ch)
	);

	walk_scoreboard sb = new();

	// When clear, neither side inserts idle cycles.
	bit          idling_on;
	int unsigned n_items;
	int unsigned n_roots;
	// Freshly drawn addresses, the first 64 kept, reused with fresh low bits so that later
	// walks revisit tables that are already populated.
	logic [VA_W-1:0] va_pool [$];

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Generous guard against a hung handshake; a correct run needs a small
	// fraction of this.
	initial begin
		#(10_000_000);
		$display("status: fail");
		$finish;
	end

	// Result side: every transfer is checked at the edge on which it happens,
	// then ready is chosen for the next cycle, with random stall bursts while idling
	// is switched on.
	initial begin
		int hold;
		hold = 0;
		out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && out_ch.valid && out_ch.ready)
				sb.check_result('{pa: out_ch.phys_addr, fault: out_ch.fault,
					size: out_ch.page_size});
			if (hold > 0) begin
				hold--;
				out_ch.ready <= 1'b0;
			end else if (idling_on && $urandom_range(0, 99) < 12) begin
				hold = $urandom_range(1, 6) - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// Presents one item and holds it until the transfer. The caller stands on a
	// rising edge; valid is left high so that a following item goes straight out.
	task automatic send_item(input walker_item_t it);
		int gap;
		if (idling_on && $urandom_range(0, 99) < 15) begin
			gap = $urandom_range(1, 6);
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid      <= 1'b1;
		in_ch.func       <= it.func;
		in_ch.virt_addr  <= it.va;
		in_ch.word_index <= it.widx;
		in_ch.word_data  <= it.wdata;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_item(it);
		n_items++;
	endtask

	// Stops sending and waits until every owed result has come back.
	task automatic await_results();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() > 0) @(posedge clk);
	endtask

	task automatic put_word(input int unsigned widx, input logic [WORD_W-1:0] data);
		walker_item_t it;
		it.func  = FUNC_WRITE;
		it.va    = {16'($urandom), $urandom};
		it.widx  = WIDX_W'(widx);
		it.wdata = data;
		send_item(it);
	endtask

	// Random table entry for the given level. Most entries are present, and
	// most table pointers land inside the store so that walks go deep; the
	// rest keep random frame bits, mostly beyond it. Bits the walker ignores are left random.
	function automatic logic [WORD_W-1:0] make_entry(input logic [LEVEL_W-1:0] lvl);
		logic [WORD_W-1:0] e;
		bit                big_page;
		e = {$urandom, $urandom};
		e[PRESENT_BIT] = ($urandom_range(0, 99) < 90);
		case (lvl)
			LVL_PT: begin
			end
			LVL_PDPT, LVL_PD: begin
				big_page = ($urandom_range(0, 99) < 30);
				e[LARGE_BIT] = big_page;
				if (!big_page && $urandom_range(0, 99) < 95)
					e[51:12] = FRAME_W'($urandom_range(0, TABLES_IN_STORE - 1));
			end
			default: begin
				if ($urandom_range(0, 99) < 95)
					e[51:12] = FRAME_W'($urandom_range(0, TABLES_IN_STORE - 1));
			end
		endcase
		return e;
	endfunction

	// Translates va, first writing every entry the walk would reach that has
	// not been written yet, as software must.
	task automatic translate(input logic [VA_W-1:0] va);
		walker_item_t  it;
		xlate_result_t probe;
		int            gw;
		int            gl;
		forever begin
			sb.walk_tables(va, probe, gw, gl);
			if (gw < 0) break;
			put_word(gw, make_entry(LEVEL_W'(gl)));
		end
		it.func  = FUNC_XLATE;
		it.va    = va;
		it.widx  = WIDX_W'($urandom);
		it.wdata = {$urandom, $urandom};
		send_item(it);
	endtask

	function automatic logic [VA_W-1:0] pick_va();
		logic [VA_W-1:0] va;
		logic [VA_W-1:0] keep_mask;
		int              cut;
		va = {16'($urandom), $urandom};
		if (va_pool.size() > 0 && $urandom_range(0, 99) < 40) begin
			// Keep the upper indices of an earlier address and redraw the rest.
			case ($urandom_range(0, 3))
				0: cut = 12;
				1: cut = 21;
				2: cut = 30;
				default: cut = 39;
			endcase
			keep_mask = ~((48'd1 << cut) - 48'd1);
			va = (va_pool[$urandom_range(0, va_pool.size() - 1)] & keep_mask)
				| (va & ~keep_mask);
		end else if (va_pool.size() < 64) begin
			va_pool.push_back(va);
		end
		return va;
	endfunction

	// Root frame writes happen only with the walker idle: all results back, then
	// a margin longer than the slowest translation.
	task automatic write_root(input logic [FRAME_W-1:0] frame);
		await_results();
		repeat (12) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= frame;
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.set_root(frame);
		n_roots++;
	endtask

	// Main stimulus.
	initial begin
		logic [FRAME_W-1:0] roots [7];
		int unsigned        budgets [7];
		int unsigned        phase_start;
		int                 p;
		n_items   = 0;
		n_roots   = 1;
		idling_on = 1'b1;
		arst_n    = 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		in_ch.valid      <= 1'b0;
		in_ch.func       <= FUNC_WRITE;
		in_ch.virt_addr  <= '0;
		in_ch.word_index <= '0;
		in_ch.word_data  <= '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, under the reset root frame of zero. Each step adds one
		// table level, first absent and then present, so that every absent-entry
		// fault and every page size comes out at least once.
		put_word(0, 64'h0);
		translate(48'h0000_0000_0000);
		// Top-level entry with its large bit set: the bit must be ignored.
		put_word(0, 64'h0000_0000_0000_1081);
		put_word(512, 64'h0);
		translate(48'h0000_0000_0000);
		// 1 GiB page with every frame bit and every offset bit set.
		put_word(512, 64'hFFFF_FFFF_C000_0081);
		translate(48'h0000_3FFF_FFFF);
		put_word(513, 64'h0000_0000_0000_2001);
		put_word(1024, 64'h0);
		translate(48'h0000_4000_0000);
		put_word(1024, 64'h000F_FFFF_FFE0_0081);
		translate(48'h0000_401F_FFFF);
		put_word(1025, 64'h0000_0000_0000_3001);
		put_word(1536, 64'h0);
		translate(48'h0000_4020_0000);
		// 4 KiB entry with all bits set, large bit included, which the last
		// level does not look at.
		put_word(1536, 64'hFFFF_FFFF_FFFF_FFFF);
		translate(48'h0000_4020_0FFF);
		// Directory pointer to a table that lies just beyond the store.
		put_word(514, 64'h0000_0000_0000_8001);
		translate(48'h0000_8000_0000);
		// Highest indices at both levels, ending on the last word of the store.
		put_word(511, 64'h0000_0000_0000_7001);
		put_word(STORE_WORDS_DEF - 1, 64'h0000_0000_0000_0081);
		translate(48'hFFFF_FFFF_FFFF);

		// Random phases, one per root frame: zero, the last table in the store,
		// a middle one, a random one, the largest frame number, a random frame far
		// beyond the store, and another random one. The last phase runs without idling.
		roots[0] = '0;
		roots[1] = FRAME_W'(TABLES_IN_STORE - 1);
		roots[2] = FRAME_W'(3);
		roots[3] = FRAME_W'($urandom_range(0, TABLES_IN_STORE - 1));
		roots[4] = '1;
		roots[5] = {8'($urandom_range(1, 255)), $urandom};
		roots[6] = FRAME_W'($urandom_range(0, TABLES_IN_STORE - 1));
		budgets = '{250, 200, 200, 150, 30, 20, 150};
		for (p = 0; p < 7; p++) begin
			write_root(roots[p]);
			if (p == 6) idling_on = 1'b0;
			phase_start = n_items;
			while (n_items - phase_start < budgets[p]) begin
				// Now and then the sender holds off until the walker has
				// returned everything it owes.
				if (idling_on && $urandom_range(0, 99) < 2) await_results();
				if ($urandom_range(0, 99) < 78)
					translate(pick_va());
				else
					put_word($urandom_range(0, (1 << WIDX_W) - 1), {$urandom, $urandom});
			end
		end

		// Drain, then leave a margin for any result that should not come.
		await_results();
		repeat (20) @(posedge clk);

		$display("run covered %0d store writes and %0d translations under %0d root frames",
			sb.n_writes, sb.n_xlates, n_roots);
		$display("faults 0..5 seen %0d/%0d/%0d/%0d/%0d/%0d, sizes none/4K/2M/1G %0d/%0d/%0d/%0d",
			sb.fault_hits[0], sb.fault_hits[1], sb.fault_hits[2], sb.fault_hits[3],
			sb.fault_hits[4], sb.fault_hits[5], sb.size_hits[0], sb.size_hits[1],
			sb.size_hits[2], sb.size_hits[3]);
		if (sb.mismatches == 0 && sb.strays == 0 && sb.pending() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d mismatches, %0d unexpected results, %0d results missing",
				sb.mismatches, sb.strays, sb.pending());
			$display("status: fail");
		end
		$finish;
	end

endmodule
